### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define KMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kmp assertion failed");

// Clocked assertion that also holds through reset.
`define KMP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kmp assertion failed");

`endif

### sv/kmp_pkg.sv
// Shared constants and types for the k-transaction max profit unit.
package kmp_pkg;

    localparam int MAX_TRANS  = 16;
    localparam int PRICE_BITS = 16;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = $clog2(MAX_TRANS + 1);
    localparam int IDX_W      = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
    localparam int HOLD_W     = 34;
    localparam int DONE_W     = 33;
    localparam int ENTRY_W    = HOLD_W + DONE_W;
    localparam int PROFIT_W   = 32;

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [CFG_W-1:0]      t_cfg;
    typedef logic [PROFIT_W-1:0]   t_profit;

    localparam logic signed [HOLD_W-1:0] HOLD_NONE = {1'b1, {(HOLD_W-1){1'b0}}};
    localparam logic signed [HOLD_W-1:0] PROFIT_MAX =
        {{(HOLD_W-PROFIT_W){1'b0}}, {PROFIT_W{1'b1}}};
    localparam logic [DONE_W-1:0] DONE_CAP = {1'b1, {(DONE_W-1){1'b0}}};

endpackage

### sv/kmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/k_transaction_max_profit_unit.sv
// Top level of the k-transaction max profit unit.
//
// Input channel (i_valid / o_ready): one price beat per day, i_last marks
// the final day of a sequence. Output channel (o_valid / i_ready): one
// result beat per sequence, given on the last price only: the best profit
// with at most K buy-then-sell transactions, clamped to 32 bits, and a
// saturation flag. K comes from i_cfg_data on i_cfg_we (clamped to 16).
//
// Each price passes through an accept state, one read-modify-write of the
// per-count state RAM per transaction count, and a finishing state. The
// counts are worked in turn: count t depends on count t-1, and the RAM's
// read data is registered. A result is registered in the finishing state
// after the last count of a last beat, once the output register is free.
//
// Reset (synchronous, active low) sets K to 1, drops the output beat and
// marks every RAM entry invalid; invalid entries read as "no holding" and
// zero profit, so no clearing pass is needed. The same valid bits are
// dropped after each last beat. A stalled result sits in the output
// register; the next price is still taken, and its own last beat waits in
// the finishing state until the output register frees up.
module k_transaction_max_profit_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  kmp_pkg::t_cfg         i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  kmp_pkg::t_price       i_price,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output kmp_pkg::t_profit      o_max_profit,
    output logic                  o_saturated
);

    import kmp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state              r_state;
    t_cfg                r_k_cfg;
    logic [CNT_W-1:0]    r_k;
    logic [IDX_W-1:0]    r_t;
    t_price              r_price;
    logic                r_last;
    logic [DONE_W-1:0]   r_prev;      // done[t-1] of the current price
    logic [MAX_TRANS-1:0] r_vld;      // entry written since last clear
    logic                r_rd_vld;
    logic                r_ovf;

    logic [IDX_W-1:0]    raddr;
    logic [ENTRY_W-1:0]  rdata;
    logic [ENTRY_W-1:0]  wdata;
    logic                we;

    logic [CNT_W-1:0]    k_eff;
    logic                in_acc;
    logic                out_free;
    logic                last_step;

    logic signed [HOLD_W-1:0] hold_rd, done_rd, price_x, prev_x;
    logic signed [HOLD_W-1:0] hold_p, buy, hold_new, best_a, best_new;
    logic                     cap;
    logic [DONE_W-1:0]        done_new;

    assign k_eff = (r_k_cfg > CFG_W'(MAX_TRANS)) ? CNT_W'(MAX_TRANS) : CNT_W'(r_k_cfg);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !o_valid || i_ready;
    assign last_step = ({1'b0, r_t} == CNT_W'(r_k - CNT_W'(1)));

    // RAM entry: {hold_balance, done_profit}
    assign raddr = (r_state == ST_IDLE) ? '0 : IDX_W'(r_t + IDX_W'(1));

    // Per-count update, rewritten so both adds run in parallel:
    //   hold = max(hold, prev - p), done = max(done, hold_old + p, prev)
    assign hold_rd = r_rd_vld ? $signed(rdata[ENTRY_W-1:DONE_W]) : HOLD_NONE;
    assign done_rd = r_rd_vld ? $signed({1'b0, rdata[DONE_W-1:0]}) : '0;
    assign price_x = $signed({{(HOLD_W-PRICE_BITS){1'b0}}, r_price});
    assign prev_x  = $signed({1'b0, r_prev});
    assign hold_p  = hold_rd + price_x;
    assign buy     = prev_x - price_x;
    assign hold_new = (buy > hold_rd) ? buy : hold_rd;
    assign best_a   = (hold_p > prev_x) ? hold_p : prev_x;
    assign best_new = (best_a > done_rd) ? best_a : done_rd;
    assign cap      = best_new > PROFIT_MAX;
    assign done_new = cap ? DONE_CAP : best_new[DONE_W-1:0];

    assign we    = (r_state == ST_RUN);
    assign wdata = {hold_new, done_new};

    kmp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_t),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k_cfg  <= CFG_W'(1);
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_ovf    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k_cfg <= i_cfg_data;
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            r_rd_vld <= r_vld[raddr];

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_price <= i_price;
                        r_last  <= i_last;
                        r_k     <= k_eff;
                        r_t     <= '0;
                        r_prev  <= '0;
                        r_state <= (k_eff == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_vld[r_t] <= 1'b1;
                    r_prev     <= done_new;
                    if (cap) begin
                        r_ovf <= 1'b1;
                    end
                    if (last_step) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_t <= IDX_W'(r_t + IDX_W'(1));
                    end
                end
                ST_DONE: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        // r_prev is done[K-1], or zero when K is zero
                        o_valid      <= 1'b1;
                        o_max_profit <= r_prev[DONE_W-1] ? {PROFIT_W{1'b1}}
                                                         : r_prev[PROFIT_W-1:0];
                        o_saturated  <= r_ovf || r_prev[DONE_W-1];
                        r_vld        <= '0;
                        r_ovf        <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/kmp_checker.sv
// Port-level checker for the k-transaction max profit unit, with its bind.
`include "assert_macros.svh"

module kmp_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  kmp_pkg::t_price       i_price,
    input  logic                  i_last,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  kmp_pkg::t_profit      o_max_profit,
    input  logic                  o_saturated
);

    import kmp_pkg::*;

    logic                in_wait;
    logic                out_wait;
    logic [PRICE_BITS:0] in_beat;
    logic [PROFIT_W:0]   out_beat;

    assign in_wait  = i_valid && !o_ready;
    assign out_wait = o_valid && !i_ready;
    assign in_beat  = {i_price, i_last};
    assign out_beat = {o_max_profit, o_saturated};

    // A result beat holds until taken
    `KMP_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> o_valid && $stable(out_beat))

    // A price beat holds until taken
    `KMP_ASSERT(a_in_hold, i_clk, i_rst_n, in_wait |=> i_valid && $stable(in_beat))

    // Reset leaves no result beat pending
    `KMP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // Input ready drops in the cycle after a price is taken
    `KMP_ASSERT(a_busy_after_beat, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // A new result beat is only raised out of a state in which the input side is not ready
    `KMP_ASSERT(a_result_from_work, i_clk, i_rst_n, !o_valid ##1 o_valid |-> $past(!o_ready))

endmodule

bind k_transaction_max_profit_unit kmp_checker u_kmp_checker (.*);
